// ----- rtl/srt_pkg.sv -----
package srt_pkg;

    // Item kinds on the input stream (tuser)
    localparam logic [1:0] FUNC_HEADER = 2'd0;
    localparam logic [1:0] FUNC_FRAME  = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // First flag byte of a busy reply header
    localparam logic [7:0] BUSY_REPLY = 8'h01;

    // Number of repeaters that the lookup may address
    localparam int REPEATER_COUNT = 16;

    // Result actions
    localparam logic [3:0] ACT_IGNORED   = 4'd0;
    localparam logic [3:0] ACT_BUSY      = 4'd1;
    localparam logic [3:0] ACT_CONF      = 4'd2;
    localparam logic [3:0] ACT_DUP       = 4'd3;
    localparam logic [3:0] ACT_UNKNOWN   = 4'd4;
    localparam logic [3:0] ACT_ADDED     = 4'd5;
    localparam logic [3:0] ACT_FULL      = 4'd6;
    localparam logic [3:0] ACT_FWD       = 4'd7;
    localparam logic [3:0] ACT_FWD_CLOSE = 4'd8;
    localparam logic [3:0] ACT_TICK      = 4'd9;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROUTES_IN_USE = 2'd0;
    localparam logic [1:0] CFG_IDLE_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_LOG_ENABLE    = 2'd2;

    // Configuration reset values
    localparam logic [4:0]  ROUTES_RESET  = 5'd16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    typedef enum logic [2:0] {
        CK_IGNORE,
        CK_BUSY,
        CK_CONF_HDR,
        CK_CONF_FRAME,
        CK_HEADER,
        CK_FRAME,
        CK_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] stream_id;
        logic        rep_ok;
        logic [3:0]  repeater;
        logic        end_flag;
        logic [9:0]  elapsed_ms;
    } cmd_t;

    typedef struct packed {
        logic [4:0]  routes_in_use;
        logic [15:0] idle_timeout_ms;
        logic        header_log_enable;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOK,
        BK_EXEC
    } back_state_t;

endpackage

// ----- rtl/stream_route_table_with_timeout.sv -----
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata ids and flags, s_tuser kind, s_tlast end flag
// m_*       out  m_tvalid/m_tready  m_tdata route result, m_tuser action
// cfg_*     in   cfg_we             cfg_addr register index, cfg_data value
//
// In the table engine an item passes a lookup state, which compares its id to
// every slot and picks the first hit and free slot, then an execute state,
// which updates the table and loads the output register. A two-deep command
// queue in front takes input words while a result waits on m_tready.
// Reset clears all routes and loads the default configuration.
module stream_route_table_with_timeout
    import srt_pkg::*;
#(
    parameter int MAX_ROUTES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // stream_id[15:0], busy_flag[23:16], conference_match[24],
    // repeater_found[25], repeater_index[29:26], elapsed_ms[39:30]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // target_repeater[3:0], slot_index[7:4], expired_slots[23:8],
    // write_header_log[24], log_as_conference[25], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata,
    // action[3:0]
    output logic [3:0]           m_tuser,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [15:0]          cfg_data
);

    cfg_t cfg_reg;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.routes_in_use     <= ROUTES_RESET;
            cfg_reg.idle_timeout_ms   <= TIMEOUT_RESET;
            cfg_reg.header_log_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ROUTES_IN_USE: cfg_reg.routes_in_use     <= cfg_data[4:0];
                CFG_IDLE_TIMEOUT:  cfg_reg.idle_timeout_ms   <= cfg_data;
                CFG_LOG_ENABLE:    cfg_reg.header_log_enable <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    srt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    srt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    srt_back #(
        .MAX_ROUTES (MAX_ROUTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/srt_front.sv -----
module srt_front
    import srt_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // stream_id[15:0], busy_flag[23:16], conference_match[24],
    // repeater_found[25], repeater_index[29:26], elapsed_ms[39:30]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [1:0]           s_tuser,
    // end_flag
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    localparam logic [6:0] REP_LIMIT = 7'(REPEATER_COUNT);

    logic [15:0] stream_id;
    logic [7:0]  busy_flag;
    logic        conf_match;
    logic        rep_found;
    logic [3:0]  rep_index;
    logic [9:0]  elapsed_ms;

    // Unpack the word
    assign stream_id  = s_tdata[15:0];
    assign busy_flag  = s_tdata[23:16];
    assign conf_match = s_tdata[24];
    assign rep_found  = s_tdata[25];
    assign rep_index  = s_tdata[29:26];
    assign elapsed_ms = s_tdata[39:30];

    // Accept while the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classify the item
    always_comb
    begin
        q_cmd.stream_id  = stream_id;
        q_cmd.rep_ok     = rep_found && ({3'b000, rep_index} < REP_LIMIT);
        q_cmd.repeater   = rep_index;
        q_cmd.end_flag   = s_tlast;
        q_cmd.elapsed_ms = elapsed_ms;
        case (s_tuser)
            FUNC_HEADER:
            begin
                if (busy_flag == BUSY_REPLY)
                    q_cmd.kind = CK_BUSY;
                else if (conf_match)
                    q_cmd.kind = CK_CONF_HDR;
                else
                    q_cmd.kind = CK_HEADER;
            end
            FUNC_FRAME:
            begin
                if (conf_match)
                    q_cmd.kind = CK_CONF_FRAME;
                else
                    q_cmd.kind = CK_FRAME;
            end
            FUNC_TICK:
                q_cmd.kind = CK_TICK;
            default:
                q_cmd.kind = CK_IGNORE;
        endcase
    end

endmodule

// ----- rtl/srt_queue.sv -----
module srt_queue
    import srt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    localparam int DEPTH = 2;

    cmd_t       entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'(DEPTH));
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- rtl/srt_back.sv -----
module srt_back
    import srt_pkg::*;
#(
    parameter int MAX_ROUTES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_empty,
    input  cmd_t                 q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // target_repeater[3:0], slot_index[7:4], expired_slots[23:8],
    // write_header_log[24], log_as_conference[25], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata,
    // action[3:0]
    output logic [3:0]           m_tuser
);

    localparam int SLOT_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int MASK_N = (MAX_ROUTES < 16) ? MAX_ROUTES : 16;

    back_state_t state_reg;
    back_state_t state_next;

    cmd_t cmd_reg;

    // Route table
    logic [MAX_ROUTES-1:0] slot_valid_reg;
    logic [MAX_ROUTES-1:0] slot_valid_next;
    logic [15:0]           slot_stream_reg [MAX_ROUTES];
    logic [15:0]           slot_stream_next [MAX_ROUTES];
    logic [3:0]            slot_rep_reg [MAX_ROUTES];
    logic [3:0]            slot_rep_next [MAX_ROUTES];
    logic [15:0]           slot_idle_reg [MAX_ROUTES];
    logic [15:0]           slot_idle_next [MAX_ROUTES];

    // Lookup results
    logic [MAX_ROUTES-1:0] enabled;
    logic [MAX_ROUTES-1:0] match_vec;
    logic [MAX_ROUTES-1:0] free_vec;
    logic [SLOT_W-1:0]     hit_idx;
    logic                  hit_any;
    logic [SLOT_W-1:0]     free_idx;
    logic                  free_any;
    logic [SLOT_W-1:0]     hit_idx_reg;
    logic                  hit_any_reg;
    logic [SLOT_W-1:0]     free_idx_reg;
    logic                  free_any_reg;

    // Tick aging
    logic [15:0]           idle_aged [MAX_ROUTES];
    logic [MAX_ROUTES-1:0] expire;
    logic [15:0]           mask_vec;

    // Result of the current command
    logic                  routes_off;
    logic [3:0]            res_action;
    logic [3:0]            res_target;
    logic [SLOT_W-1:0]     res_slot;
    logic                  res_wlog;
    logic                  res_lconf;
    logic [SLOT_W+3:0]     res_slot_ext;

    // Output register
    logic                  out_valid_reg;
    logic [3:0]            out_action_reg;
    logic [3:0]            out_target_reg;
    logic [3:0]            out_slot_reg;
    logic [15:0]           out_expired_reg;
    logic                  out_wlog_reg;
    logic                  out_lconf_reg;

    logic                  out_free;
    logic                  commit;
    logic                  load_cmd;

    assign out_free   = !out_valid_reg || m_tready;
    assign routes_off = (cfg.routes_in_use == 5'd0);

    // Mark slots below the configured count
    always_comb
    begin
        for (int i = 0; i < MAX_ROUTES; i++)
            enabled[i] = (7'(i) < {2'b00, cfg.routes_in_use});
    end

    // Compare the id against every slot
    always_comb
    begin
        for (int i = 0; i < MAX_ROUTES; i++)
        begin
            match_vec[i] = enabled[i] && slot_valid_reg[i]
                           && (slot_stream_reg[i] == cmd_reg.stream_id);
            free_vec[i]  = enabled[i] && !slot_valid_reg[i];
        end
    end

    // Pick the lowest matching and lowest free slot
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = MAX_ROUTES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
                hit_idx = SLOT_W'(i);
            if (free_vec[i])
                free_idx = SLOT_W'(i);
        end
        hit_any  = |match_vec;
        free_any = |free_vec;
    end

    // Age live slots with saturation
    always_comb
    begin
        logic [16:0] sum;
        for (int i = 0; i < MAX_ROUTES; i++)
        begin
            sum          = {1'b0, slot_idle_reg[i]} + {7'b0, cmd_reg.elapsed_ms};
            idle_aged[i] = sum[16] ? 16'hFFFF : sum[15:0];
            expire[i]    = enabled[i] && slot_valid_reg[i]
                           && (cfg.idle_timeout_ms != 16'd0)
                           && (idle_aged[i] >= cfg.idle_timeout_ms);
        end
    end

    // Report expiries of the first sixteen slots
    always_comb
    begin
        mask_vec = '0;
        mask_vec[MASK_N-1:0] = expire[MASK_N-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!q_empty)
                    state_next = BK_LOOK;
            BK_LOOK:
                state_next = BK_EXEC;
            BK_EXEC:
                if (out_free)
                    state_next = q_empty ? BK_IDLE : BK_LOOK;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        commit   = 1'b0;
        load_cmd = 1'b0;
        unique case (state_reg)
            BK_IDLE:
                load_cmd = !q_empty;
            BK_LOOK:
                load_cmd = 1'b0;
            BK_EXEC:
            begin
                commit   = out_free;
                load_cmd = out_free && !q_empty;
            end
            default:
            begin
                commit   = 1'b0;
                load_cmd = 1'b0;
            end
        endcase
    end

    assign q_pop = load_cmd;

    // Work out the result of the command
    always_comb
    begin
        res_action = ACT_IGNORED;
        res_target = 4'd0;
        res_slot   = '0;
        res_wlog   = 1'b0;
        res_lconf  = 1'b0;
        case (cmd_reg.kind)
            CK_BUSY:
                res_action = ACT_BUSY;
            CK_CONF_HDR:
            begin
                res_action = ACT_CONF;
                res_wlog   = cfg.header_log_enable;
                res_lconf  = 1'b1;
            end
            CK_CONF_FRAME:
                res_action = ACT_CONF;
            CK_HEADER:
            begin
                if (routes_off)
                    res_action = ACT_IGNORED;
                else if (hit_any_reg)
                begin
                    res_action = ACT_DUP;
                    res_slot   = hit_idx_reg;
                    res_target = slot_rep_reg[hit_idx_reg];
                end
                else if (!cmd_reg.rep_ok)
                    res_action = ACT_UNKNOWN;
                else if (free_any_reg)
                begin
                    res_action = ACT_ADDED;
                    res_slot   = free_idx_reg;
                    res_target = cmd_reg.repeater;
                    res_wlog   = cfg.header_log_enable;
                end
                else
                    res_action = ACT_FULL;
            end
            CK_FRAME:
            begin
                if (hit_any_reg)
                begin
                    res_action = cmd_reg.end_flag ? ACT_FWD_CLOSE : ACT_FWD;
                    res_slot   = hit_idx_reg;
                    res_target = slot_rep_reg[hit_idx_reg];
                end
            end
            CK_TICK:
                res_action = ACT_TICK;
            default:
                res_action = ACT_IGNORED;
        endcase
    end

    assign res_slot_ext = {4'b0000, res_slot};

    // Update the table on commit
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        for (int i = 0; i < MAX_ROUTES; i++)
        begin
            slot_stream_next[i] = slot_stream_reg[i];
            slot_rep_next[i]    = slot_rep_reg[i];
            slot_idle_next[i]   = slot_idle_reg[i];
        end
        if (commit)
        begin
            case (cmd_reg.kind)
                CK_HEADER:
                begin
                    if (res_action == ACT_ADDED)
                    begin
                        slot_valid_next[free_idx_reg]  = 1'b1;
                        slot_stream_next[free_idx_reg] = cmd_reg.stream_id;
                        slot_rep_next[free_idx_reg]    = cmd_reg.repeater;
                        slot_idle_next[free_idx_reg]   = 16'd0;
                    end
                end
                CK_FRAME:
                begin
                    if (hit_any_reg)
                    begin
                        slot_idle_next[hit_idx_reg] = 16'd0;
                        if (cmd_reg.end_flag)
                            slot_valid_next[hit_idx_reg] = 1'b0;
                    end
                end
                CK_TICK:
                begin
                    for (int i = 0; i < MAX_ROUTES; i++)
                    begin
                        if (enabled[i] && slot_valid_reg[i])
                        begin
                            slot_idle_next[i] = idle_aged[i];
                            if (expire[i])
                                slot_valid_next[i] = 1'b0;
                        end
                    end
                end
                default:
                begin
                    slot_valid_next = slot_valid_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Table payload, command and lookup registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ROUTES; i++)
        begin
            slot_stream_reg[i] <= slot_stream_next[i];
            slot_rep_reg[i]    <= slot_rep_next[i];
            slot_idle_reg[i]   <= slot_idle_next[i];
        end
        if (load_cmd)
            cmd_reg <= q_head;
        if (state_reg == BK_LOOK)
        begin
            hit_idx_reg  <= hit_idx;
            hit_any_reg  <= hit_any;
            free_idx_reg <= free_idx;
            free_any_reg <= free_any;
        end
        if (commit)
        begin
            out_action_reg  <= res_action;
            out_target_reg  <= res_target;
            out_slot_reg    <= res_slot_ext[3:0];
            out_expired_reg <= (cmd_reg.kind == CK_TICK) ? mask_vec : 16'd0;
            out_wlog_reg    <= res_wlog;
            out_lconf_reg   <= res_lconf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = {6'd0, out_lconf_reg, out_wlog_reg, out_expired_reg,
                       out_slot_reg, out_target_reg};

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_look_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LOOK) |=> (state_reg == BK_EXEC))
        else $error("lookup not followed by execute");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_mask_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_action_reg != ACT_TICK) |-> (out_expired_reg == 16'd0))
        else $error("expiry mask on a non-tick result");
`endif

endmodule
